// ===== rtl/digraph_matrix_connectivity_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the digraph connectivity core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIGRAPH_MATRIX_CONNECTIVITY_CORE_ASSERT_SVH
`define DIGRAPH_MATRIX_CONNECTIVITY_CORE_ASSERT_SVH

// same-cycle implication
`define DMC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmc: implication check failed");

// next-cycle implication
`define DMC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmc: next-cycle check failed");

`endif

// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants for the digraph adjacency matrix connectivity core.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_MAX     = MAX_VERTICES * (MAX_VERTICES - 1);

    // word field widths
    localparam int OP_W     = 3;
    localparam int VTX_W    = 4;
    localparam int WGT_W    = 16;
    localparam int VCNT_W   = 5;
    localparam int DEG_W    = 5;
    localparam int EDGES_W  = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST    = 3'd2;
    localparam logic [OP_W-1:0] OP_OUT_DEG = 3'd3;
    localparam logic [OP_W-1:0] OP_IN_DEG  = 3'd4;
    localparam logic [OP_W-1:0] OP_STRONG  = 3'd5;
    localparam logic [OP_W-1:0] OP_WEAK    = 3'd6;

    // register index (paddr[2])
    localparam logic REG_VCOUNT = 1'b0;

    typedef logic [MAX_VERTICES-1:0] t_vset;

endpackage

// ===== rtl/digraph_matrix_connectivity_core.sv =====
// ----------------------------------------------------------------------------
// digraph_matrix_connectivity_core
// Directed graph held as an adjacency bit matrix, with edge edit, degree
// and strong/weak connectivity queries run by a small sequencer.
// ----------------------------------------------------------------------------
// Channel   | Dir | Handshake                  | Contents
// s_axis    | in  | s_axis_tvalid/tready       | tuser opcode, tdata vertices+weight
// m_axis    | out | m_axis_tvalid/tready       | tuser status, tdata flag/degree/edges
// apb       | in  | psel/penable/pwrite/pready | vertex_count at byte address 0
//
// Per word: IDLE accepts it, EXEC runs insert/remove/test or rejects bad
// vertices, degree queries walk in DEG, weak and strong checks expand in
// EXPAND (one matrix bit read or one frontier expansion per cycle; strong runs
// forward, then backward), and RESULT offers the result as input is ready again.
// Synchronous active-low reset clears matrix, edge count, output valid; vcount = 16.
// A stalled output holds its word; the sequencer waits until it is free.
// ----------------------------------------------------------------------------
`include "digraph_matrix_connectivity_core_assert.svh"

module digraph_matrix_connectivity_core
    import dmc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // stream in
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // [3:0] src_vertex, [7:4] dst_vertex,
                                               // [23:8] edge_weight (signed)
    input  logic [OP_W-1:0]     s_axis_tuser,  // [2:0] opcode
    // stream out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // [0] answer_flag, [5:1] degree,
                                               // [13:6] edges_now, [15:14] zero
    output logic                m_axis_tuser,  // [0] status
    // config
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DEG    = 3'd2;
    localparam logic [2:0] S_EXPAND = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    // control state
    logic [2:0]          r_state, n_state;
    t_vset               r_adj [MAX_VERTICES];
    t_vset               n_adj [MAX_VERTICES];
    logic [EDGES_W-1:0]  r_edges, n_edges;
    logic [VCNT_W-1:0]   r_vcount;
    logic                r_out_valid, n_out_valid;

    // working payload
    logic [OP_W-1:0]     r_op, n_op;
    logic [VTX_W-1:0]    r_src, n_src;
    logic [VTX_W-1:0]    r_dst, n_dst;
    logic                r_wnz, n_wnz;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic [DEG_W-1:0]    r_deg, n_deg;
    t_vset               r_set, n_set;
    t_vset               r_fset, n_fset;
    logic                r_phase, n_phase;
    logic                r_status, n_status;
    logic                r_flag, n_flag;
    logic                r_out_status, n_out_status;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    logic                in_acc;
    logic                cfg_wr;
    logic [CNT_W-1:0]    used_n;
    t_vset               vmask;
    t_vset               live;
    t_vset               fwd_hit;
    t_vset               bwd_hit;
    t_vset               exp_next;
    logic                use_fwd;
    logic                use_bwd;
    logic [IDX_W-1:0]    row_idx;
    logic [IDX_W-1:0]    col_idx;
    t_vset               row_sel;
    logic                adj_bit;
    logic                bad_pair;
    logic                bad_src;
    logic                last_step;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // APB: always ready, one register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VCOUNT);
    assign prdata = (paddr[2] == REG_VCOUNT) ? {{(APB_DW-VCNT_W){1'b0}}, r_vcount}
                                             : '0;

    // vertex count in use: zero reads as one, above the matrix size clamps
    always_comb begin
        if (r_vcount == '0) begin
            used_n = CNT_W'(1);
        end else if (CNT_W'(r_vcount) > CNT_W'(MAX_VERTICES)) begin
            used_n = CNT_W'(MAX_VERTICES);
        end else begin
            used_n = CNT_W'(r_vcount);
        end
    end

    always_comb begin
        for (int u = 0; u < MAX_VERTICES; u++) begin
            vmask[u] = (CNT_W'(u) < r_n);
        end
    end

    // single row read: EXEC reads (src,dst), out-degree walks row src,
    // in-degree walks column src
    always_comb begin
        if (r_state == S_EXEC) begin
            row_idx = IDX_W'(r_src);
            col_idx = IDX_W'(r_dst);
        end else if (r_op == OP_OUT_DEG) begin
            row_idx = IDX_W'(r_src);
            col_idx = r_cnt;
        end else begin
            row_idx = r_cnt;
            col_idx = IDX_W'(r_src);
        end
    end
    assign row_sel = r_adj[row_idx];
    assign adj_bit = row_sel[col_idx];

    assign bad_pair  = ({1'b0, r_src} >= r_n) || ({1'b0, r_dst} >= r_n);
    assign bad_src   = ({1'b0, r_src} >= r_n);
    assign last_step = (r_cnt == IDX_W'(r_n - CNT_W'(1)));

    // frontier expansion: forward along rows, backward along columns
    assign live    = r_set & vmask;
    assign use_fwd = (r_op == OP_WEAK) || !r_phase;
    assign use_bwd = (r_op == OP_WEAK) || r_phase;
    always_comb begin
        for (int u = 0; u < MAX_VERTICES; u++) begin
            fwd_hit[u] = 1'b0;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                fwd_hit[u] = fwd_hit[u] | (live[v] & r_adj[v][u]);
            end
            bwd_hit[u] = |(r_adj[u] & live);
        end
    end
    assign exp_next = r_set | (((use_fwd ? fwd_hit : '0) | (use_bwd ? bwd_hit : '0))
                               & vmask);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_adj        = r_adj;
        n_edges      = r_edges;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_src        = r_src;
        n_dst        = r_dst;
        n_wnz        = r_wnz;
        n_n          = r_n;
        n_cnt        = r_cnt;
        n_deg        = r_deg;
        n_set        = r_set;
        n_fset       = r_fset;
        n_phase      = r_phase;
        n_status     = r_status;
        n_flag       = r_flag;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = s_axis_tuser;
                    n_src    = s_axis_tdata[3:0];
                    n_dst    = s_axis_tdata[7:4];
                    n_wnz    = (s_axis_tdata[23:8] != '0);
                    n_n      = used_n;
                    n_status = 1'b0;
                    n_flag   = 1'b0;
                    n_deg    = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                case (r_op)
                    OP_INSERT: begin
                        if (bad_pair) begin
                            n_status = 1'b1;
                        end else if (!adj_bit && (r_src != r_dst) && r_wnz) begin
                            n_adj[r_src][r_dst] = 1'b1;
                            n_edges             = r_edges + EDGES_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (bad_pair) begin
                            n_status = 1'b1;
                        end else if (adj_bit) begin
                            n_adj[r_src][r_dst] = 1'b0;
                            n_edges             = r_edges - EDGES_W'(1);
                        end
                    end
                    OP_TEST: begin
                        if (bad_pair) begin
                            n_status = 1'b1;
                        end else begin
                            n_flag = adj_bit;
                        end
                    end
                    OP_OUT_DEG, OP_IN_DEG: begin
                        if (bad_src) begin
                            n_status = 1'b1;
                        end else begin
                            n_cnt   = '0;
                            n_state = S_DEG;
                        end
                    end
                    OP_STRONG, OP_WEAK: begin
                        n_set   = t_vset'(1);
                        n_phase = 1'b0;
                        n_cnt   = '0;
                        n_state = S_EXPAND;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_DEG: begin
                n_deg = r_deg + DEG_W'(adj_bit);
                n_cnt = r_cnt + IDX_W'(1);
                if (last_step) begin
                    n_state = S_RESULT;
                end
            end
            S_EXPAND: begin
                n_set = exp_next;
                n_cnt = r_cnt + IDX_W'(1);
                if (last_step) begin
                    if ((r_op == OP_STRONG) && !r_phase) begin
                        // forward done, restart from vertex 0 backwards
                        n_fset  = exp_next;
                        n_set   = t_vset'(1);
                        n_phase = 1'b1;
                        n_cnt   = '0;
                    end else begin
                        if (r_op == OP_STRONG) begin
                            n_flag = (r_fset == vmask) && (exp_next == vmask);
                        end else begin
                            n_flag = (exp_next == vmask);
                        end
                        n_state = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = {2'b00, r_edges, r_deg, r_flag};
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_edges     <= '0;
            r_out_valid <= 1'b0;
            r_vcount    <= VCNT_W'(MAX_VERTICES);
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_edges     <= n_edges;
            r_out_valid <= n_out_valid;
            r_adj       <= n_adj;
            if (cfg_wr) begin
                r_vcount <= pwdata[VCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_wnz        <= n_wnz;
        r_n          <= n_n;
        r_cnt        <= n_cnt;
        r_deg        <= n_deg;
        r_set        <= n_set;
        r_fset       <= n_fset;
        r_phase      <= n_phase;
        r_status     <= n_status;
        r_flag       <= n_flag;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    // checks
    `DMC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `DMC_ASSERT_IMP(a_edges_bounded, 1'b1, r_edges <= EDGES_W'(EDGE_MAX))
    `DMC_ASSERT_IMP(a_root_reached, r_state == S_EXPAND, r_set[0])
    `DMC_ASSERT_IMP(a_bad_vertex_quiet, m_axis_tvalid && m_axis_tuser, m_axis_tdata[5:0] == 6'd0)

endmodule

// ===== tb/sv/digraph_matrix_connectivity_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digraph_matrix_connectivity_core_tb
// Self-checking bench for the digraph adjacency matrix core. Words go in on
// the slave stream and answers are checked against an in-bench graph model
// as they leave the master stream. The vertex count is reprogrammed over APB
// between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module digraph_matrix_connectivity_core_tb;
    import dmc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int SETTLE_CYCLES = 2 * MAX_VERTICES + 8;  // worst-case word plus margin
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int RX_HOLD_CYCLES = 400;

    // opcode 7 has no meaning in the package; the core must answer it as a no-op
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
        logic [WGT_W-1:0] weight;
    } t_graph_word;

    typedef struct packed {
        logic               status;
        logic               flag;
        logic [DEG_W-1:0]   degree;
        logic [EDGES_W-1:0] edges;
    } t_graph_answer;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // ---------------------------------------------------------------- DUT I/O
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // [3:0] src, [7:4] dst, [23:8] weight
    logic [OP_W-1:0]     s_axis_tuser = '0;   // [2:0] opcode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // [0] flag, [5:1] degree, [13:6] edges
    logic                m_axis_tuser;        // [0] status
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    digraph_matrix_connectivity_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------- graph model
    // Weights are kept as well as presence, though only nonzero-ness is visible.
    logic [WGT_W-1:0]   weight_mat [MAX_VERTICES][MAX_VERTICES];
    logic [EDGES_W-1:0] edge_count;
    logic [VCNT_W-1:0]  vcount_reg;

    t_graph_word   pending_words[$];     // queued for the driver
    t_graph_answer expected_answers[$];  // one per accepted word, oldest first
    t_graph_word   cur_word;             // word currently on the slave bus

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int rx_hold_left  = 0;
    int error_count   = 0;

    // 0 behaves as 1, anything above the matrix size as the matrix size
    function automatic int used_vertices();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
        return int'(vcount_reg);
    endfunction

    // Set of vertices reachable from vertex 0, following edges forwards,
    // backwards, or both (weak). One frontier expansion per pass.
    function automatic t_vset reach_from_root(input int n, input bit fwd, input bit bwd);
        t_vset seen;
        t_vset grown;
        int pass, v, u;
        seen = t_vset'(1);
        for (pass = 0; pass < n; pass++) begin
            grown = seen;
            for (v = 0; v < n; v++) begin
                if (seen[v]) begin
                    for (u = 0; u < n; u++) begin
                        if ((fwd && weight_mat[v][u] != 0) || (bwd && weight_mat[u][v] != 0))
                            grown[u] = 1'b1;
                    end
                end
            end
            if (grown == seen) break;
            seen = grown;
        end
        return seen;
    endfunction

    // Applies one word to the model graph and returns the answer it must give.
    function automatic t_graph_answer apply_graph_op(input t_graph_word w);
        t_graph_answer a;
        t_vset         all_set;
        t_vset         fwd_set;
        t_vset         bwd_set;
        int            n, i;
        a = '0;
        n = used_vertices();
        all_set = t_vset'((64'd1 << n) - 1);
        case (w.opcode)
            OP_INSERT, OP_REMOVE, OP_TEST: begin
                if (w.src >= n || w.dst >= n) begin
                    a.status = 1'b1;
                end else if (w.opcode == OP_INSERT) begin
                    // occupied slot, self-loop and zero weight are silently dropped
                    if (weight_mat[w.src][w.dst] == 0 && w.src != w.dst && w.weight != 0) begin
                        weight_mat[w.src][w.dst] = w.weight;
                        edge_count++;
                    end
                end else if (w.opcode == OP_REMOVE) begin
                    if (weight_mat[w.src][w.dst] != 0) begin
                        weight_mat[w.src][w.dst] = '0;
                        edge_count--;
                    end
                end else begin
                    a.flag = (weight_mat[w.src][w.dst] != 0);
                end
            end
            OP_OUT_DEG, OP_IN_DEG: begin
                if (w.src >= n) begin
                    a.status = 1'b1;
                end else begin
                    for (i = 0; i < n; i++) begin
                        if (w.opcode == OP_OUT_DEG ? weight_mat[w.src][i] != 0
                                                   : weight_mat[i][w.src] != 0)
                            a.degree++;
                    end
                end
            end
            OP_STRONG: begin
                fwd_set = reach_from_root(n, 1'b1, 1'b0);
                bwd_set = reach_from_root(n, 1'b0, 1'b1);
                a.flag  = (fwd_set == all_set) && (bwd_set == all_set);
            end
            OP_WEAK: begin
                a.flag = (reach_from_root(n, 1'b1, 1'b1) == all_set);
            end
            default: ;  // spare opcode: no change, zero answer
        endcase
        a.edges = edge_count;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 100)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------- slave driver
    // Holds tvalid until the word is taken; the answer is predicted at the
    // accepting edge so the model sees words in exactly the core's order.
    always @(posedge i_clk) begin : word_driver
        t_graph_word nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_answers.push_back(apply_graph_op(cur_word));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_words.pop_front();
                    cur_word      <= nxt;
                    s_axis_tdata  <= {nxt.weight, nxt.dst, nxt.src};
                    s_axis_tuser  <= nxt.opcode;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------- master monitor
    always @(posedge i_clk) begin : answer_monitor
        t_graph_answer want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected word (tdata)", int'(m_axis_tdata), -1);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", int'(m_axis_tuser), int'(want.status));
                    if (m_axis_tdata[0] !== want.flag)
                        report_mismatch("answer_flag", int'(m_axis_tdata[0]), int'(want.flag));
                    if (m_axis_tdata[5:1] !== want.degree)
                        report_mismatch("degree", int'(m_axis_tdata[5:1]), int'(want.degree));
                    if (m_axis_tdata[13:6] !== want.edges)
                        report_mismatch("edges_now", int'(m_axis_tdata[13:6]), int'(want.edges));
                end
            end
            m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off, so the core fills and backs up its input
    always @(posedge i_clk) begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // ---------------------------------------------------------- stimulus helpers
    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct <= (mode == IDLE_SEND) ? 86 : (mode == IDLE_BOTH) ? 22 : 0;
        rx_stall_pct  <= (mode == IDLE_RECV) ? 86 : (mode == IDLE_BOTH) ? 22 : 0;
    endtask

    // APB write: setup then access; the model follows once the access edge passes
    task automatic write_vcount(input logic [VCNT_W-1:0] vc);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_VCOUNT, 2'b00};
        pwdata  <= APB_DW'(vc);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vcount_reg = vc;
    endtask

    // sender stops here until every answer is back and the core has settled
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_word(input logic [OP_W-1:0] op, input int s, input int d,
                                       input logic [WGT_W-1:0] w);
        t_graph_word x;
        x.opcode = op;
        x.src    = VTX_W'(s);
        x.dst    = VTX_W'(d);
        x.weight = w;
        pending_words.push_back(x);
    endfunction

    // Mostly in-range vertices; one in ten anywhere in the 4-bit field.
    function automatic t_graph_word random_word(input int n);
        t_graph_word w;
        int pick;
        pick = $urandom_range(99);
        if      (pick < 34) w.opcode = OP_INSERT;
        else if (pick < 54) w.opcode = OP_REMOVE;
        else if (pick < 66) w.opcode = OP_TEST;
        else if (pick < 74) w.opcode = OP_OUT_DEG;
        else if (pick < 82) w.opcode = OP_IN_DEG;
        else if (pick < 89) w.opcode = OP_STRONG;
        else if (pick < 96) w.opcode = OP_WEAK;
        else                w.opcode = OP_SPARE;
        w.src    = VTX_W'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1));
        w.dst    = VTX_W'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1));
        w.weight = ($urandom_range(9) == 0) ? '0 : WGT_W'($urandom);
        return w;
    endfunction

    task automatic run_random(input logic [VCNT_W-1:0] vc, input t_idle_mode mode,
                              input int count);
        write_vcount(vc);
        set_idling(mode);
        repeat (count) pending_words.push_back(random_word(used_vertices()));
        wait_drained();
    endtask

    task automatic shuffle_words(ref t_graph_word q[$]);
        t_graph_word t;
        int i, j;
        for (i = q.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = q[i];
            q[i] = q[j];
            q[j] = t;
        end
    endtask

    // connectivity checks plus one random degree or edge query
    function automatic void queue_probe(input int n);
        queue_word(OP_STRONG, 0, 0, '0);
        queue_word(OP_WEAK, 0, 0, '0);
        queue_word(($urandom_range(1) == 0) ? OP_OUT_DEG
                   : ($urandom_range(1) == 0) ? OP_IN_DEG : OP_TEST,
                   $urandom_range(n - 1), $urandom_range(n - 1), '0);
    endfunction

    // Builds the complete graph in random order, then tears it down in another,
    // probing connectivity on the way up and down.
    task automatic queue_fill_and_empty(input int n);
        t_graph_word pairs[$];
        t_graph_word w;
        int s, d;
        for (s = 0; s < n; s++) begin
            for (d = 0; d < n; d++) begin
                if (s != d) begin
                    w.opcode = OP_INSERT;
                    w.src    = VTX_W'(s);
                    w.dst    = VTX_W'(d);
                    w.weight = WGT_W'($urandom_range(65534) + 1);
                    pairs.push_back(w);
                end
            end
        end
        shuffle_words(pairs);
        foreach (pairs[k]) begin
            pending_words.push_back(pairs[k]);
            if (k % 16 == 15) queue_probe(n);
        end
        shuffle_words(pairs);
        foreach (pairs[k]) begin
            w = pairs[k];
            w.opcode = OP_REMOVE;
            pending_words.push_back(w);
            if (k % 16 == 15) queue_probe(n);
        end
    endtask

    // ---------------------------------------------------------- test sequence
    initial begin
        foreach (weight_mat[a, b]) weight_mat[a][b] = '0;
        edge_count = '0;
        vcount_reg = VCNT_W'(MAX_VERTICES);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at the reset vertex count of 16: insert rules and queries.
        set_idling(IDLE_NONE);
        queue_word(OP_INSERT, 0, 1, 16'h7FFF);     // largest positive weight
        queue_word(OP_INSERT, 15, 14, 16'h8000);   // most negative weight
        queue_word(OP_INSERT, 0, 1, 16'h0005);     // slot already taken
        queue_word(OP_INSERT, 3, 3, 16'h0007);     // self-loop
        queue_word(OP_INSERT, 2, 3, 16'h0000);     // zero weight
        queue_word(OP_TEST, 0, 1, '0);
        queue_word(OP_TEST, 1, 0, '0);
        queue_word(OP_REMOVE, 2, 3, '0);           // nothing to remove
        queue_word(OP_OUT_DEG, 0, 0, '0);
        queue_word(OP_IN_DEG, 14, 0, '0);
        queue_word(OP_STRONG, 0, 0, '0);
        queue_word(OP_WEAK, 0, 0, '0);
        queue_word(OP_SPARE, 5, 9, 16'hFFFF);
        queue_word(OP_REMOVE, 0, 1, '0);
        queue_word(OP_INSERT, 1, 0, 16'hFFFF);
        queue_word(OP_TEST, 1, 0, '0);
        wait_drained();

        // Shrunken count: bad vertices for every opcode that takes one;
        // the edge from vertex 15 to vertex 14 stays counted though out of view.
        write_vcount(VCNT_W'(4));
        queue_word(OP_INSERT, 4, 0, 16'h0001);
        queue_word(OP_INSERT, 0, 15, 16'h0001);
        queue_word(OP_REMOVE, 3, 9, '0);
        queue_word(OP_TEST, 15, 15, '0);
        queue_word(OP_OUT_DEG, 4, 0, '0);
        queue_word(OP_IN_DEG, 7, 0, '0);
        queue_word(OP_WEAK, 0, 0, '0);
        queue_word(OP_STRONG, 0, 0, '0);
        repeat (40) pending_words.push_back(random_word(used_vertices()));
        wait_drained();

        // Single vertex: always connected, no edge can be added.
        write_vcount(VCNT_W'(1));
        set_idling(IDLE_SEND);
        queue_word(OP_STRONG, 0, 0, '0);
        queue_word(OP_WEAK, 0, 0, '0);
        queue_word(OP_INSERT, 0, 0, 16'h0003);
        queue_word(OP_OUT_DEG, 0, 0, '0);
        queue_word(OP_TEST, 0, 1, '0);
        repeat (15) pending_words.push_back(random_word(used_vertices()));
        wait_drained();

        run_random(VCNT_W'(0), IDLE_RECV, 15);     // zero count acts as one

        // Full graph build and teardown. The receiver holds off first, so the
        // core backs up while the sender keeps offering words.
        write_vcount(VCNT_W'(MAX_VERTICES));
        set_idling(IDLE_NONE);
        rx_hold_left <= RX_HOLD_CYCLES;
        queue_fill_and_empty(MAX_VERTICES);
        wait_drained();

        run_random(VCNT_W'(31), IDLE_BOTH, 50);    // above the matrix size
        run_random(VCNT_W'(5),  IDLE_SEND, 50);
        run_random(VCNT_W'(3),  IDLE_RECV, 50);
        run_random(VCNT_W'(12), IDLE_BOTH, 50);
        run_random(VCNT_W'(16), IDLE_NONE, 50);
        run_random(VCNT_W'(2),  IDLE_SEND, 50);

        if (error_count == 0)
            $display("[digraph_matrix_connectivity_core] OK");
        else
            $display("[digraph_matrix_connectivity_core] ERROR");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[digraph_matrix_connectivity_core] ERROR");
        $finish;
    end

endmodule
